/* rtl/msmc_pkg.sv */
`timescale 1ns / 1ps

package msmc_pkg;

   // operating modes
   localparam logic [1:0] MODE_INIT      = 2'd0;
   localparam logic [1:0] MODE_READY     = 2'd1;
   localparam logic [1:0] MODE_RUN       = 2'd2;
   localparam logic [1:0] MODE_EMERGENCY = 2'd3;

   // command bytes (ascii)
   localparam logic [7:0] CMD_STOP  = 8'h53;
   localparam logic [7:0] CMD_FWD   = 8'h46;
   localparam logic [7:0] CMD_BACK  = 8'h42;
   localparam logic [7:0] CMD_LEFT  = 8'h4C;
   localparam logic [7:0] CMD_RIGHT = 8'h52;

   // request kinds
   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_COMMAND = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_BLINK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_BLINK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMERG_BLINK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TMO    = 2'd3;

   // register reset values
   localparam logic [15:0] RST_READY_BLINK = 16'd500;
   localparam logic [15:0] RST_RUN_BLINK   = 16'd100;
   localparam logic [15:0] RST_EMERG_BLINK = 16'd50;
   localparam logic [15:0] RST_LINK_TMO    = 16'd1000;

   // field widths
   localparam int CFG_W   = 16;
   localparam int CMD_W   = 8;
   localparam int SPEED_W = 16;
   localparam int RIGHT_W = 15;
   localparam int QMAG_W  = 14;

   // |s|*130/500 == (|s| * SCALE_MULT) >> SCALE_SHIFT, exact for |s| <= 32768
   localparam logic [22:0] SCALE_MULT  = 23'd4362085;
   localparam int          SCALE_SHIFT = 24;

   typedef struct packed {
      logic [CFG_W-1:0] ready_blink;
      logic [CFG_W-1:0] run_blink;
      logic [CFG_W-1:0] emerg_blink;
      logic [CFG_W-1:0] link_timeout;
   } cfg_type;

   typedef struct packed {
      logic                      is_move;
      logic signed [SPEED_W-1:0] left;
      logic signed [RIGHT_W-1:0] right;
   } drive_type;

   typedef struct packed {
      logic                      buzzer;
      logic                      led;
      logic signed [RIGHT_W-1:0] right;
      logic signed [SPEED_W-1:0] left;
      logic [1:0]                mode;
   } result_type;

endpackage

/* rtl/msmc_csr.sv */
`timescale 1ns / 1ps

module msmc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [msmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msmc_pkg::CFG_W-1:0]        csr_wdata,
   output msmc_pkg::cfg_type                 cfg
);

   msmc_pkg::cfg_type cfg_ff;

   // register file write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_blink  <= msmc_pkg::RST_READY_BLINK;
         cfg_ff.run_blink    <= msmc_pkg::RST_RUN_BLINK;
         cfg_ff.emerg_blink  <= msmc_pkg::RST_EMERG_BLINK;
         cfg_ff.link_timeout <= msmc_pkg::RST_LINK_TMO;
      end else if (csr_we) begin
         case (csr_index)
            msmc_pkg::CSR_READY_BLINK: cfg_ff.ready_blink  <= csr_wdata;
            msmc_pkg::CSR_RUN_BLINK:   cfg_ff.run_blink    <= csr_wdata;
            msmc_pkg::CSR_EMERG_BLINK: cfg_ff.emerg_blink  <= csr_wdata;
            msmc_pkg::CSR_LINK_TMO:    cfg_ff.link_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/msmc_drive.sv */
`timescale 1ns / 1ps

module msmc_drive (
   input  logic [msmc_pkg::CMD_W-1:0]          cmd,
   input  logic signed [msmc_pkg::SPEED_W-1:0] speed,
   output msmc_pkg::drive_type                 drive
);

   localparam int PROD_W = msmc_pkg::SPEED_W + 23;

   logic                            left_neg;
   logic                            right_neg;
   logic [msmc_pkg::SPEED_W-1:0]    mag;
   logic [PROD_W-1:0]               prod;
   logic [msmc_pkg::QMAG_W-1:0]     q_mag;
   logic [msmc_pkg::RIGHT_W-1:0]    q_ext;
   logic                            speed_min;

   // decode direction
   assign left_neg  = (cmd == msmc_pkg::CMD_BACK) || (cmd == msmc_pkg::CMD_LEFT);
   assign right_neg = (cmd == msmc_pkg::CMD_BACK) || (cmd == msmc_pkg::CMD_RIGHT);
   assign drive.is_move = (cmd == msmc_pkg::CMD_FWD) || (cmd == msmc_pkg::CMD_BACK) ||
                          (cmd == msmc_pkg::CMD_LEFT) || (cmd == msmc_pkg::CMD_RIGHT);

   // magnitude scaled by 130/500 via reciprocal multiply
   assign mag   = speed[msmc_pkg::SPEED_W-1] ? (~speed + 1'b1) : speed;
   assign prod  = PROD_W'(mag) * PROD_W'(msmc_pkg::SCALE_MULT);
   assign q_mag = prod[msmc_pkg::SCALE_SHIFT +: msmc_pkg::QMAG_W];
   assign q_ext = {1'b0, q_mag};

   // left drive, negation of the most negative speed saturates
   assign speed_min = (speed == {1'b1, {(msmc_pkg::SPEED_W-1){1'b0}}});
   always_comb begin
      if (!left_neg)
         drive.left = speed;
      else if (speed_min)
         drive.left = {1'b0, {(msmc_pkg::SPEED_W-1){1'b1}}};
      else
         drive.left = -speed;
   end

   // right drive sign follows speed sign and direction
   assign drive.right = (speed[msmc_pkg::SPEED_W-1] ^ right_neg) ? -q_ext : q_ext;

endmodule

/* rtl/msmc_core.sv */
`timescale 1ns / 1ps

module msmc_core #(
   parameter int AGE_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        action,
   input  logic [msmc_pkg::CMD_W-1:0]  cmd,
   input  msmc_pkg::drive_type         drive,
   input  msmc_pkg::cfg_type           cfg,
   output msmc_pkg::result_type        result_in
);

   localparam int CMP_W = (AGE_WIDTH > msmc_pkg::CFG_W) ? AGE_WIDTH : msmc_pkg::CFG_W;

   logic [1:0]                          mode_ff,   mode_in;
   logic [AGE_WIDTH-1:0]                link_ff,   link_in;
   logic [AGE_WIDTH-1:0]                blink_ff,  blink_in;
   logic                                led_ff,    led_in;
   logic                                buzzer_ff, buzzer_in;
   logic signed [msmc_pkg::SPEED_W-1:0] left_ff,   left_in;
   logic signed [msmc_pkg::RIGHT_W-1:0] right_ff,  right_in;

   logic [AGE_WIDTH-1:0]  link_inc;
   logic [AGE_WIDTH-1:0]  blink_inc;
   logic [msmc_pkg::CFG_W-1:0] period;
   logic                  blink_hit;
   logic                  link_expired;

   // saturating age counters
   assign link_inc  = (&link_ff)  ? link_ff  : link_ff  + 1'b1;
   assign blink_inc = (&blink_ff) ? blink_ff : blink_ff + 1'b1;

   // blink period of current mode
   always_comb begin
      case (mode_ff)
         msmc_pkg::MODE_READY:     period = cfg.ready_blink;
         msmc_pkg::MODE_RUN:       period = cfg.run_blink;
         msmc_pkg::MODE_EMERGENCY: period = cfg.emerg_blink;
         default:                  period = cfg.ready_blink;
      endcase
   end

   assign blink_hit    = CMP_W'(blink_inc) >= CMP_W'(period);
   assign link_expired = CMP_W'(link_inc) > CMP_W'(cfg.link_timeout);

   // next state
   always_comb begin
      mode_in   = mode_ff;
      link_in   = link_ff;
      blink_in  = blink_ff;
      led_in    = led_ff;
      buzzer_in = buzzer_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (action == msmc_pkg::ACT_TICK) begin
         link_in  = link_inc;
         blink_in = blink_inc;
         if (mode_ff != msmc_pkg::MODE_INIT && blink_hit) begin
            led_in   = ~led_ff;
            blink_in = '0;
         end
         case (mode_ff)
            msmc_pkg::MODE_READY: begin
               left_in   = '0;
               right_in  = '0;
               buzzer_in = 1'b0;
            end
            msmc_pkg::MODE_RUN: begin
               if (link_expired)
                  mode_in = msmc_pkg::MODE_EMERGENCY;
               buzzer_in = 1'b0;
            end
            msmc_pkg::MODE_EMERGENCY: begin
               left_in   = '0;
               right_in  = '0;
               buzzer_in = 1'b1;
            end
            default: ;
         endcase
      end else begin
         left_in  = '0;
         right_in = '0;
         if (cmd == msmc_pkg::CMD_STOP) begin
            mode_in = msmc_pkg::MODE_READY;
            link_in = '0;
         end else if (drive.is_move && mode_ff != msmc_pkg::MODE_EMERGENCY) begin
            mode_in  = msmc_pkg::MODE_RUN;
            link_in  = '0;
            left_in  = drive.left;
            right_in = drive.right;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= msmc_pkg::MODE_INIT;
         link_ff   <= '0;
         blink_ff  <= '0;
         led_ff    <= 1'b0;
         buzzer_ff <= 1'b0;
         left_ff   <= '0;
         right_ff  <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         link_ff   <= link_in;
         blink_ff  <= blink_in;
         led_ff    <= led_in;
         buzzer_ff <= buzzer_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   assign result_in.mode   = mode_in;
   assign result_in.left   = left_in;
   assign result_in.right  = right_in;
   assign result_in.led    = led_in;
   assign result_in.buzzer = buzzer_in;

endmodule

/* rtl/motion_safety_mode_controller.sv */
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | tdata: command, speed; tuser: action
// rsp      | out       | rsp_tvalid/rsp_tready  | tdata: mode, drives, led, buzzer
// csr      | in        | csr_we                 | csr_index, csr_wdata
//
// one request per cycle sustained while rsp_tready stays high; each request yields one
// response, which passes the input register and then the result register
// the rate is set by the state update between those registers
// reset is synchronous; it restores the register defaults and the init mode
// a stalled response holds the result register; the input register keeps taking
// a request whenever the one it holds moves on in the same cycle

module motion_safety_mode_controller #(
   parameter int AGE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // command_code[7:0], speed[23:8]
   input  logic                           req_tuser,  // action[0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,  // mode[1:0], left_drive[17:2],
                                                      // right_drive[32:18], led_level[33],
                                                      // buzzer_on[34], zero[39:35]
   input  logic                           csr_we,
   input  logic [msmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [msmc_pkg::CFG_W-1:0]     csr_wdata
);

   logic                                in_valid_ff;
   logic                                in_action_ff;
   logic [msmc_pkg::CMD_W-1:0]          in_cmd_ff;
   logic signed [msmc_pkg::SPEED_W-1:0] in_speed_ff;
   logic                                rsp_valid_ff;
   msmc_pkg::result_type                rsp_data_ff;

   logic                 out_free;
   logic                 step;
   logic                 req_take;
   msmc_pkg::cfg_type    cfg;
   msmc_pkg::drive_type  drive;
   msmc_pkg::result_type result_in;

   // flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_tready)
         in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tuser;
         in_cmd_ff    <= req_tdata[7:0];
         in_speed_ff  <= req_tdata[23:8];
      end
   end

   msmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msmc_drive u_drive (
      .cmd   (in_cmd_ff),
      .speed (in_speed_ff),
      .drive (drive)
   );

   msmc_core #(
      .AGE_WIDTH (AGE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .action    (in_action_ff),
      .cmd       (in_cmd_ff),
      .drive     (drive),
      .cfg       (cfg),
      .result_in (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (out_free)
         rsp_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (step)
         rsp_data_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule
